// ===== rtl/tgmf_pkg.sv =====
// Shared types and constants of the tile grid motion filter.
package tgmf_pkg;

	localparam int PW = 20;
	localparam int IW = 12;
	localparam int CELL_ROW_W = 7;
	localparam int CELL_COL_W = 9;

	localparam logic [3:0] SIDE_TOP    = 4'b0001;
	localparam logic [3:0] SIDE_BOTTOM = 4'b0010;
	localparam logic [3:0] SIDE_LEFT   = 4'b0100;
	localparam logic [3:0] SIDE_RIGHT  = 4'b1000;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_FILTER = 1'b1;

	typedef struct packed {
		logic                  op;
		logic [CELL_ROW_W-1:0] cell_row;
		logic [CELL_COL_W-1:0] cell_col;
		logic [3:0]            cell_flags;
		logic [10:0]           rect_x;
		logic [8:0]            rect_y;
		logic [6:0]            rect_w;
		logic [6:0]            rect_h;
		logic signed [3:0]     move_dx;
		logic signed [3:0]     move_dy;
	} req_t;

	typedef struct packed {
		logic signed [3:0] allowed_dx;
		logic signed [3:0] allowed_dy;
	} rsp_t;

	typedef struct packed {
		logic              scan;
		logic [IW-1:0]     line;
		logic [IW-1:0]     first;
		logic [IW-1:0]     last;
		logic [3:0]        mask;
		logic signed [3:0] hit_val;
		logic signed [3:0] pass_val;
	} axis_t;

	typedef struct packed {
		logic                  is_write;
		logic [CELL_ROW_W-1:0] wr_row;
		logic [CELL_COL_W-1:0] wr_col;
		logic [3:0]            wr_flags;
		axis_t                 x;
		axis_t                 y;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_X,
		ST_SCAN_Y,
		ST_DRAIN,
		ST_DONE
	} back_state_t;

endpackage

// ===== rtl/tgmf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module tgmf_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 65536
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tgmf_fifo.sv =====
// Two-entry command queue between the classifier and the scan engine.
module tgmf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tgmf_pkg::cmd_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tgmf_pkg::cmd_t  pop_data
);

	tgmf_pkg::cmd_t mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/tgmf_front.sv =====
// Front end: accepts transactions and turns them into write or scan commands.
module tgmf_front #(
	parameter int CELL_WIDTH_LOG2  = 2,
	parameter int CELL_HEIGHT_LOG2 = 2,
	parameter int GRID_COLUMNS     = 512,
	parameter int GRID_ROWS        = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tgmf_pkg::req_t  req,
	input  logic            clear_busy,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output tgmf_pkg::cmd_t  cmd
);

	localparam int PW = tgmf_pkg::PW;
	localparam int IW = tgmf_pkg::IW;
	localparam logic signed [PW-1:0] MAP_W = PW'(GRID_COLUMNS << CELL_WIDTH_LOG2);
	localparam logic signed [PW-1:0] MAP_H = PW'(GRID_ROWS << CELL_HEIGHT_LOG2);
	localparam logic signed [PW-1:0] LIM_X = PW'(1 << CELL_WIDTH_LOG2);
	localparam logic signed [PW-1:0] LIM_Y = PW'(1 << CELL_HEIGHT_LOG2);

	tgmf_pkg::req_t req_s1;
	logic           valid_s1;
	logic           push;

	assign push      = valid_s1 && cmd_ready;
	assign cmd_valid = valid_s1;
	assign req_ready = !clear_busy && (!valid_s1 || push);

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [PW-1:0] w;
		logic signed [PW-1:0] h;
		logic signed [PW-1:0] dx;
		logic signed [PW-1:0] dy;
		logic signed [PW-1:0] x2;
		logic signed [PW-1:0] y2;
		logic signed [PW-1:0] nx;
		logic signed [PW-1:0] ny;
		logic signed [PW-1:0] t;
		logic [IW-1:0]        r0;
		logic [IW-1:0]        r1;
		logic [IW-1:0]        c0;
		logic [IW-1:0]        c1;

		x  = PW'(req_s1.rect_x);
		y  = PW'(req_s1.rect_y);
		w  = PW'(req_s1.rect_w);
		h  = PW'(req_s1.rect_h);
		if (req_s1.rect_w == '0) begin
			w = PW'(1);
		end
		if (req_s1.rect_h == '0) begin
			h = PW'(1);
		end
		dx = PW'(req_s1.move_dx);
		dy = PW'(req_s1.move_dy);
		if (dx > LIM_X) begin
			dx = LIM_X;
		end else if (dx < -LIM_X) begin
			dx = -LIM_X;
		end
		if (dy > LIM_Y) begin
			dy = LIM_Y;
		end else if (dy < -LIM_Y) begin
			dy = -LIM_Y;
		end
		x2 = x + w - PW'(1);
		y2 = y + h - PW'(1);
		r0 = IW'(y >>> CELL_HEIGHT_LOG2);
		r1 = IW'(y2 >>> CELL_HEIGHT_LOG2);
		c0 = IW'(x >>> CELL_WIDTH_LOG2);
		c1 = IW'(x2 >>> CELL_WIDTH_LOG2);
		nx = '0;
		ny = '0;
		t  = '0;

		cmd          = '0;
		cmd.is_write = (req_s1.op == tgmf_pkg::OP_WRITE);
		cmd.wr_row   = req_s1.cell_row;
		cmd.wr_col   = req_s1.cell_col;
		cmd.wr_flags = req_s1.cell_flags;

		cmd.x.first = r0;
		cmd.x.last  = r1;
		if (dx < 0) begin
			nx = x + dx;
			if (nx < 0) begin
				t = -x;
				cmd.x.pass_val = t[3:0];
			end else begin
				cmd.x.scan     = (nx >>> CELL_WIDTH_LOG2) != (x >>> CELL_WIDTH_LOG2);
				cmd.x.line     = IW'(nx >>> CELL_WIDTH_LOG2);
				cmd.x.mask     = tgmf_pkg::SIDE_RIGHT;
				t              = ((x >>> CELL_WIDTH_LOG2) <<< CELL_WIDTH_LOG2) - x;
				cmd.x.hit_val  = t[3:0];
				cmd.x.pass_val = dx[3:0];
			end
		end else if (dx > 0) begin
			nx = x2 + dx;
			if (nx >= MAP_W) begin
				t = MAP_W - PW'(1) - x2;
				if (t < 0) begin
					t = '0;
				end
				cmd.x.pass_val = t[3:0];
			end else begin
				cmd.x.scan     = (nx >>> CELL_WIDTH_LOG2) != (x2 >>> CELL_WIDTH_LOG2);
				cmd.x.line     = IW'(nx >>> CELL_WIDTH_LOG2);
				cmd.x.mask     = tgmf_pkg::SIDE_LEFT;
				t              = ((nx >>> CELL_WIDTH_LOG2) <<< CELL_WIDTH_LOG2) - PW'(1) - x2;
				cmd.x.hit_val  = t[3:0];
				cmd.x.pass_val = dx[3:0];
			end
		end

		cmd.y.first = c0;
		cmd.y.last  = c1;
		if (dy < 0) begin
			ny = y + dy;
			if (ny < 0) begin
				t = -y;
				cmd.y.pass_val = t[3:0];
			end else begin
				cmd.y.scan     = (ny >>> CELL_HEIGHT_LOG2) != (y >>> CELL_HEIGHT_LOG2);
				cmd.y.line     = IW'(ny >>> CELL_HEIGHT_LOG2);
				cmd.y.mask     = tgmf_pkg::SIDE_BOTTOM;
				t              = ((y >>> CELL_HEIGHT_LOG2) <<< CELL_HEIGHT_LOG2) - y;
				cmd.y.hit_val  = t[3:0];
				cmd.y.pass_val = dy[3:0];
			end
		end else if (dy > 0) begin
			ny = y2 + dy;
			if (ny >= MAP_H) begin
				t = MAP_H - PW'(1) - y2;
				if (t < 0) begin
					t = '0;
				end
				cmd.y.pass_val = t[3:0];
			end else begin
				cmd.y.scan     = (ny >>> CELL_HEIGHT_LOG2) != (y2 >>> CELL_HEIGHT_LOG2);
				cmd.y.line     = IW'(ny >>> CELL_HEIGHT_LOG2);
				cmd.y.mask     = tgmf_pkg::SIDE_TOP;
				t              = ((ny >>> CELL_HEIGHT_LOG2) <<< CELL_HEIGHT_LOG2) - PW'(1) - y2;
				cmd.y.hit_val  = t[3:0];
				cmd.y.pass_val = dy[3:0];
			end
		end
	end

endmodule

// ===== rtl/tgmf_back.sv =====
// Back end: clears and writes the cell map and scans cells for filter commands.
module tgmf_back #(
	parameter int GRID_COLUMNS = 512,
	parameter int GRID_ROWS    = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  tgmf_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tgmf_pkg::rsp_t  rsp,
	output logic            clear_busy
);

	localparam int IW = tgmf_pkg::IW;
	localparam int ROW_LIM = 1 << tgmf_pkg::CELL_ROW_W;
	localparam int COL_LIM = 1 << tgmf_pkg::CELL_COL_W;
	localparam int MEM_ROWS = (GRID_ROWS < ROW_LIM) ? GRID_ROWS : ROW_LIM;
	localparam int MEM_COLS = (GRID_COLUMNS < COL_LIM) ? GRID_COLUMNS : COL_LIM;
	localparam int DEPTH = MEM_ROWS * MEM_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	tgmf_pkg::back_state_t st_q, st_d;
	tgmf_pkg::cmd_t        cur_q;
	tgmf_pkg::rsp_t        rsp_q;
	logic [IW-1:0]         idx_q, idx_d;
	logic [AW-1:0]         clr_q, clr_d;
	logic                  hit_x_q;
	logic                  hit_y_q;
	logic                  rd_pend_q;
	logic                  rd_axis_q;
	logic [3:0]            rd_mask_q;
	logic                  rd_in_q;
	logic                  rsp_valid_q;
	logic                  load;
	logic                  finish;
	logic                  rd_issue;
	logic                  rd_axis_d;
	logic [3:0]            rd_mask_d;
	logic [IW-1:0]         sc_row;
	logic [IW-1:0]         sc_col;
	logic                  sc_in;
	logic                  wr_in;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [3:0]            wdata;
	logic [AW-1:0]         raddr;
	logic [3:0]            rdata;
	logic                  rd_hit;

	tgmf_ram #(
		.WIDTH (4),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sc_row = (st_q == tgmf_pkg::ST_SCAN_Y) ? cur_q.y.line : idx_q;
	assign sc_col = (st_q == tgmf_pkg::ST_SCAN_Y) ? idx_q : cur_q.x.line;
	assign sc_in  = (int'(sc_row) < MEM_ROWS) && (int'(sc_col) < MEM_COLS);
	assign raddr  = AW'(int'(sc_row) * MEM_COLS + int'(sc_col));
	assign wr_in  = (int'(cmd.wr_row) < MEM_ROWS) && (int'(cmd.wr_col) < MEM_COLS);
	assign rd_hit = rd_pend_q && rd_in_q && ((rdata & rd_mask_q) != 4'b0000);

	assign clear_busy = (st_q == tgmf_pkg::ST_CLEAR);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tgmf_pkg::ST_CLEAR;
			clr_q       <= '0;
			rd_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			clr_q     <= clr_d;
			rd_pend_q <= rd_issue;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		rd_axis_q <= rd_axis_d;
		rd_mask_q <= rd_mask_d;
		rd_in_q   <= sc_in;
		if (load) begin
			cur_q   <= cmd;
			hit_x_q <= 1'b0;
			hit_y_q <= 1'b0;
		end else if (rd_hit) begin
			if (rd_axis_q) begin
				hit_y_q <= 1'b1;
			end else begin
				hit_x_q <= 1'b1;
			end
		end
		if (finish) begin
			rsp_q.allowed_dx <= hit_x_q ? cur_q.x.hit_val : cur_q.x.pass_val;
			rsp_q.allowed_dy <= hit_y_q ? cur_q.y.hit_val : cur_q.y.pass_val;
		end
	end

	always_comb begin
		st_d      = st_q;
		idx_d     = idx_q;
		clr_d     = clr_q;
		cmd_ready = 1'b0;
		we        = 1'b0;
		waddr     = AW'(int'(cmd.wr_row) * MEM_COLS + int'(cmd.wr_col));
		wdata     = cmd.wr_flags;
		load      = 1'b0;
		finish    = 1'b0;
		rd_issue  = 1'b0;
		rd_axis_d = 1'b0;
		rd_mask_d = cur_q.x.mask;
		case (st_q)
			tgmf_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 4'b0000;
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) begin
					st_d = tgmf_pkg::ST_IDLE;
				end
			end
			tgmf_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd.is_write) begin
						we = wr_in;
					end else begin
						load = 1'b1;
						if (cmd.x.scan) begin
							st_d  = tgmf_pkg::ST_SCAN_X;
							idx_d = cmd.x.first;
						end else if (cmd.y.scan) begin
							st_d  = tgmf_pkg::ST_SCAN_Y;
							idx_d = cmd.y.first;
						end else begin
							st_d = tgmf_pkg::ST_DRAIN;
						end
					end
				end
			end
			tgmf_pkg::ST_SCAN_X: begin
				rd_issue  = 1'b1;
				rd_axis_d = 1'b0;
				rd_mask_d = cur_q.x.mask;
				if (idx_q == cur_q.x.last) begin
					if (cur_q.y.scan) begin
						st_d  = tgmf_pkg::ST_SCAN_Y;
						idx_d = cur_q.y.first;
					end else begin
						st_d = tgmf_pkg::ST_DRAIN;
					end
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			tgmf_pkg::ST_SCAN_Y: begin
				rd_issue  = 1'b1;
				rd_axis_d = 1'b1;
				rd_mask_d = cur_q.y.mask;
				if (idx_q == cur_q.y.last) begin
					st_d = tgmf_pkg::ST_DRAIN;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			tgmf_pkg::ST_DRAIN: begin
				st_d = tgmf_pkg::ST_DONE;
			end
			tgmf_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					finish = 1'b1;
					st_d   = tgmf_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = tgmf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/tile_grid_motion_filter.sv =====
// Top level of the tile grid motion filter: front end, command queue, scan engine.
//
// channel | signals                    | payload         | direction
// --------+----------------------------+-----------------+----------
// request | req_valid, req_ready, req  | tgmf_pkg::req_t | in
// result  | rsp_valid, rsp_ready, rsp  | tgmf_pkg::rsp_t | out
//
// A write transaction passes the front-end register and the command queue to the map and gives no result.
// A filter transaction gives a result and holds the scan engine while it reads Nx + Ny map
// cells, where Nx is the number of rows spanned when the move crosses into a new column
// (else 0) and Ny the number of columns spanned when it crosses into a new row: one map
// read per cycle.
// After reset the map is cleared one cell per cycle, min(GRID_ROWS,128) *
// min(GRID_COLUMNS,512) cells (65536 by default); req_ready stays low meanwhile.
// A stalled result holds the engine; the queue keeps taking up to two commands.
module tile_grid_motion_filter #(
	parameter int CELL_WIDTH_LOG2  = 2,
	parameter int CELL_HEIGHT_LOG2 = 2,
	parameter int GRID_COLUMNS     = 512,
	parameter int GRID_ROWS        = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tgmf_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tgmf_pkg::rsp_t  rsp
);

	tgmf_pkg::cmd_t front_cmd;
	tgmf_pkg::cmd_t back_cmd;
	logic           front_valid;
	logic           front_ready;
	logic           back_valid;
	logic           back_ready;
	logic           clear_busy;

	tgmf_front #(
		.CELL_WIDTH_LOG2  (CELL_WIDTH_LOG2),
		.CELL_HEIGHT_LOG2 (CELL_HEIGHT_LOG2),
		.GRID_COLUMNS     (GRID_COLUMNS),
		.GRID_ROWS        (GRID_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.clear_busy (clear_busy),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	tgmf_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	tgmf_back #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (back_valid),
		.cmd_ready  (back_ready),
		.cmd        (back_cmd),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.clear_busy (clear_busy)
	);

endmodule
